[src/min_tracking_stack_assert.svh]
// ----------------------------------------------------------------------------
// min_tracking_stack_assert.svh
// assertion macros used by the checker file of the min tracking stack
// ----------------------------------------------------------------------------
`ifndef MIN_TRACKING_STACK_ASSERT_SVH
`define MIN_TRACKING_STACK_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define MTS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/mts_pkg.sv]
// ----------------------------------------------------------------------------
// mts_pkg
// types and codes shared by the min tracking stack modules
// ----------------------------------------------------------------------------
package mts_pkg;

	localparam int DATA_W = 32;
	localparam int COUNT_W = 8;

	// command codes
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP = 1'b1;

	typedef logic signed [DATA_W-1:0] mts_data_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} mts_status_t;

	// one stored entry: tag marks an encoded word (2*value - old minimum)
	typedef struct packed {
		logic      tag;
		mts_data_t data;
	} mts_entry_t;

	// shift control broadcast along the cell row
	typedef struct packed {
		logic push;
		logic pop;
	} mts_shift_t;

	typedef struct packed {
		logic      command;
		mts_data_t value;
	} mts_cmd_t;

	typedef struct packed {
		mts_status_t        status;
		mts_data_t          popped_value;
		mts_data_t          top_value;
		mts_data_t          min_value;
		logic               is_empty;
		logic               is_full;
		logic [COUNT_W-1:0] entry_count;
	} mts_rsp_t;

endpackage

[src/mts_cell.sv]
// ----------------------------------------------------------------------------
// mts_cell
// one stack slot: takes the entry from above on a push, from below on a pop
// ----------------------------------------------------------------------------
module mts_cell (
	input  logic               clk,
	input  mts_pkg::mts_shift_t shift,
	input  mts_pkg::mts_entry_t from_above,
	input  mts_pkg::mts_entry_t from_below,
	output mts_pkg::mts_entry_t entry
);
	import mts_pkg::*;

	mts_entry_t entry_q;

	// shift down on push, up on pop, hold otherwise
	always_ff @(posedge clk) begin
		if (shift.push) begin
			entry_q <= from_above;
		end else if (shift.pop) begin
			entry_q <= from_below;
		end
	end

	assign entry = entry_q;

endmodule

[src/min_tracking_stack.sv]
// ----------------------------------------------------------------------------
// min_tracking_stack
// LIFO stack with constant-time minimum, built as a row of shifting cells
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid, cmd_stall, cmd_data) carries push/pop commands.
//   rsp channel (rsp_valid, rsp_stall, rsp_data) returns one result per
//   command: status, popped value, new top, minimum, empty/full and count.
//   The result is registered at the accepting edge.
//   Throughput is one command per cycle while cmd_stall is low; the whole
//   cell row shifts by one slot at once, so the top and the entry below it
//   are always at fixed cells and no memory read sits in the path.
//   Reset empties the stack (count and minimum cleared, response register
//   emptied); cell contents are left as they are and are never read
//   while they lie above the count.
//   While a result waits and rsp_stall is high, cmd_stall is raised and
//   the held result does not change.
// ----------------------------------------------------------------------------
module min_tracking_stack #(
	parameter int DEPTH = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  mts_pkg::mts_cmd_t cmd_data,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output mts_pkg::mts_rsp_t rsp_data
);
	import mts_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0] cnt_q;
	mts_data_t        min_q;
	logic             rsp_valid_q;
	mts_rsp_t         rsp_q;

	mts_entry_t cells [DEPTH];
	mts_entry_t new_entry;
	mts_entry_t top_src;
	mts_shift_t shift;

	logic             cmd_fire;
	logic             empty;
	logic             full;
	logic [CNT_W-1:0] nxt_cnt;
	mts_data_t        nxt_min;
	mts_data_t        popped;
	mts_status_t      status;
	mts_rsp_t         rsp_nxt;

	assign cmd_stall = rsp_valid_q & rsp_stall;
	assign cmd_fire  = cmd_valid & ~cmd_stall;
	assign empty     = (cnt_q == '0);
	assign full      = (cnt_q == CNT_W'(DEPTH));

	// command decode and minimum tracking
	always_comb begin
		nxt_cnt        = cnt_q;
		nxt_min        = min_q;
		new_entry.tag  = 1'b0;
		new_entry.data = cmd_data.value;
		popped         = '0;
		status         = ST_OK;
		shift          = '0;
		top_src        = cells[0];
		if (cmd_data.command == CMD_PUSH) begin
			if (full) begin
				status = ST_OVERFLOW;
			end else begin
				shift.push = cmd_fire;
				nxt_cnt    = cnt_q + CNT_W'(1);
				top_src    = new_entry;
				if (empty) begin
					nxt_min = cmd_data.value;
				end else if (cmd_data.value < min_q) begin
					new_entry.tag  = 1'b1;
					new_entry.data = {cmd_data.value[DATA_W-2:0], 1'b0} - min_q;
					nxt_min        = cmd_data.value;
					top_src        = new_entry;
				end
			end
		end else begin
			if (empty) begin
				status = ST_UNDERFLOW;
			end else begin
				shift.pop = cmd_fire;
				nxt_cnt   = cnt_q - CNT_W'(1);
				top_src   = cells[1];
				if (cells[0].tag) begin
					popped  = min_q;
					nxt_min = {min_q[DATA_W-2:0], 1'b0} - cells[0].data;
				end else begin
					popped = cells[0].data;
				end
			end
		end
	end

	// result assembly from the state after the command
	always_comb begin
		rsp_nxt.status       = status;
		rsp_nxt.popped_value = popped;
		rsp_nxt.is_empty     = (nxt_cnt == '0);
		rsp_nxt.is_full      = (nxt_cnt == CNT_W'(DEPTH));
		rsp_nxt.entry_count  = COUNT_W'(nxt_cnt);
		if (nxt_cnt == '0) begin
			rsp_nxt.top_value = '0;
			rsp_nxt.min_value = '0;
		end else begin
			rsp_nxt.top_value = top_src.tag ? nxt_min : top_src.data;
			rsp_nxt.min_value = nxt_min;
		end
	end

	// cell row: cell 0 is the top of the stack
	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			mts_entry_t above;
			mts_entry_t below;
			if (gi == 0) begin : g_head
				assign above = new_entry;
			end else begin : g_body
				assign above = cells[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_tail
				assign below = '0;
			end else begin : g_inner
				assign below = cells[gi+1];
			end
			mts_cell u_cell (
				.clk       (clk),
				.shift     (shift),
				.from_above(above),
				.from_below(below),
				.entry     (cells[gi])
			);
		end
	endgenerate

	// stack pointer and minimum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			min_q <= '0;
		end else if (cmd_fire) begin
			cnt_q <= nxt_cnt;
			min_q <= nxt_min;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

[src/mts_checker.sv]
// ----------------------------------------------------------------------------
// mts_checker
// port-level checks on the min tracking stack, bound to the top level
// ----------------------------------------------------------------------------
`include "min_tracking_stack_assert.svh"

module mts_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input mts_pkg::mts_rsp_t rsp_data
);
	import mts_pkg::*;

	// a stalled result stays and holds its payload
	`MTS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "stalled result dropped")
	`MTS_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_data), "stalled result changed")

	// underflow leaves an empty stack and pops nothing
	`MTS_ASSERT_NOW(a_underflow, rsp_valid && rsp_data.status == ST_UNDERFLOW,
		rsp_data.is_empty && rsp_data.popped_value == '0, "underflow on non-empty stack")

	// overflow only reported on a full stack
	`MTS_ASSERT_NOW(a_overflow, rsp_valid && rsp_data.status == ST_OVERFLOW,
		rsp_data.is_full && !rsp_data.is_empty, "overflow on non-full stack")

	// an empty stack reports zero count, top and minimum
	`MTS_ASSERT_NOW(a_empty, rsp_valid && rsp_data.is_empty,
		rsp_data.entry_count == '0 && rsp_data.top_value == '0 && rsp_data.min_value == '0,
		"empty stack with nonzero fields")

endmodule

bind min_tracking_stack mts_checker u_mts_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp_data (rsp_data)
);
